// ===== rtl/dbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dbm_pkg
// Shared constants for the push-button debouncer with auto-repeat.
// ----------------------------------------------------------------------------
package dbm_pkg;

	localparam int BUTTONS_DEF    = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam int DELAY_W = 15;
	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);

	// register word indexes on the configuration port
	localparam logic REG_DEBOUNCE_DELAY = 1'b0;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// stream payload layout
	localparam int PORT_W     = 8;
	localparam int BUTTON_W   = 3;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 8;

	localparam logic MODE_ON_CLICK = 1'b0;
	localparam logic MODE_REPEAT   = 1'b1;

endpackage

// ===== rtl/dbm_ram.sv =====
// ----------------------------------------------------------------------------
// dbm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dbm_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read-first: a read of the entry being written returns the old word
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/button_debounce_with_modes.sv =====
// ----------------------------------------------------------------------------
// button_debounce_with_modes
// Per-button debouncer with on-click single fire and while-pressed repeat.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave beat is one poll of one button: s_tdata carries the sampled
//   port byte, the button number (its bit in the byte, active low) and the
//   mode. Every beat yields exactly one master beat whose bit 0 is fire.
//   Per-button press and release counters and the latched flag live in one
//   RAM word per button; the poll reads the word when it is accepted, the
//   update is computed from the read data the next cycle and written back.
//   A write-back that collides with the next poll's read of the same button
//   is forwarded, so polls of one button may follow every cycle.
//   An accepted slave beat passes the update stage, then the output register.
//   Throughput: one poll per cycle while m_tready stays high.
//   A stalled output holds its beat; one more poll is taken into the update
//   stage, then s_tready drops until the output drains.
//   Reset clears all counters and flags at once through per-button valid
//   bits and sets debounce_delay to 100. Buttons at or above BUTTONS give
//   fire low and leave all state alone. Users must write debounce_delay via
//   the APB port at byte address 0 only while idle; the block does not check.
// ----------------------------------------------------------------------------
module button_debounce_with_modes #(
	parameter int BUTTONS    = dbm_pkg::BUTTONS_DEF,
	parameter int COUNT_BITS = dbm_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// [7:0] port_value, [10:8] button, [11] mode, [15:12] zero
	input  logic [dbm_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [0] fire, [7:1] zero
	output logic [dbm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dbm_pkg::PADDR_W-1:0]   paddr,
	input  logic [dbm_pkg::PDATA_W-1:0]   pwdata,
	output logic [dbm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int IDX_W   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam int ENTRY_W = 2 * COUNT_BITS + 1;
	localparam int CMP_W   = (COUNT_BITS > dbm_pkg::DELAY_W) ? COUNT_BITS : dbm_pkg::DELAY_W;

	// configuration
	logic [dbm_pkg::DELAY_W-1:0] delay_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == dbm_pkg::REG_DEBOUNCE_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= dbm_pkg::DELAY_RESET;
		end else if (cfg_wr) begin
			delay_q <= pwdata[dbm_pkg::DELAY_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == dbm_pkg::REG_DEBOUNCE_DELAY) begin
			prdata = dbm_pkg::PDATA_W'(delay_q);
		end
	end

	// input unpack
	logic [dbm_pkg::PORT_W-1:0]   in_port;
	logic [dbm_pkg::BUTTON_W-1:0] in_button;
	logic                         in_mode;
	logic                         in_accept;

	assign in_port   = s_tdata[dbm_pkg::PORT_W-1:0];
	assign in_button = s_tdata[dbm_pkg::PORT_W +: dbm_pkg::BUTTON_W];
	assign in_mode   = s_tdata[dbm_pkg::PORT_W + dbm_pkg::BUTTON_W];
	assign in_accept = s_tvalid && s_tready;

	// pipeline control
	logic s1_valid_q;
	logic out_valid_q;
	logic adv;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || adv;

	logic [IDX_W-1:0] idx_s1;
	logic             in_range_s1;
	logic             pressed_s1;
	logic             mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			idx_s1      <= in_button[IDX_W-1:0];
			in_range_s1 <= (32'(in_button) < BUTTONS);
			pressed_s1  <= !in_port[in_button];
			mode_s1     <= in_mode;
		end
	end

	// state memory
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	dbm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (BUTTONS),
		.AW    (IDX_W)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.re    (in_accept),
		.raddr (in_button[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// entries never written read as zero
	logic [BUTTONS-1:0] ent_valid_q;
	logic               fwd_valid_q;
	logic [IDX_W-1:0]   fwd_idx_q;
	logic [ENTRY_W-1:0] fwd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			fwd_valid_q <= 1'b0;
		end else if (ram_we) begin
			ent_valid_q[idx_s1] <= 1'b1;
			fwd_valid_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= ram_wdata;
		end
	end

	// update of the selected button
	logic [ENTRY_W-1:0]    cur;
	logic [COUNT_BITS-1:0] pc, rc, pc_inc, rc_inc, pc_nx, rc_nx;
	logic                  lat, lat_nx, fire_s1;

	always_comb begin
		if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			cur = fwd_data_q;
		end else if (ent_valid_q[idx_s1]) begin
			cur = ram_rdata;
		end else begin
			cur = '0;
		end
		pc  = cur[COUNT_BITS-1:0];
		rc  = cur[COUNT_BITS +: COUNT_BITS];
		lat = cur[ENTRY_W-1];

		// counters saturate at all ones
		pc_inc = (pc == '1) ? pc : pc + 1'b1;
		rc_inc = (rc == '1) ? rc : rc + 1'b1;

		pc_nx   = pc;
		rc_nx   = rc;
		lat_nx  = lat;
		fire_s1 = 1'b0;

		// repeat mode counts out a latched button whatever the pin shows
		if ((mode_s1 == dbm_pkg::MODE_REPEAT) ? lat : !pressed_s1) begin
			pc_nx = '0;
			rc_nx = rc_inc;
			if (CMP_W'(rc_inc) > CMP_W'(delay_q)) begin
				lat_nx = 1'b0;
				rc_nx  = '0;
			end
		end else if (mode_s1 == dbm_pkg::MODE_ON_CLICK || pressed_s1) begin
			pc_nx = pc_inc;
			rc_nx = '0;
			if (CMP_W'(pc_inc) > CMP_W'(delay_q)) begin
				lat_nx  = 1'b1;
				fire_s1 = !lat;
				pc_nx   = '0;
			end
		end
	end

	assign ram_we    = s1_valid_q && adv && in_range_s1;
	assign ram_wdata = {lat_nx, rc_nx, pc_nx};

	// output register
	logic fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			fire_q <= fire_s1 && in_range_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = dbm_pkg::M_TDATA_W'(fire_q);

`ifndef SYNTHESIS
	a_we_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(idx_s1) < BUTTONS))
		else $error("state write to a button beyond range");

	a_fire_unlatched: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && fire_s1) |-> (!lat && lat_nx))
		else $error("fire from a latched button");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (fwd_valid_q && ent_valid_q[fwd_idx_q]))
		else $error("written entry not marked valid");

	a_out_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && adv) |=> out_valid_q)
		else $error("update stage beat lost");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the push-button debouncer with auto-repeat. A table of
// directed polls is followed by random press/release runs per button under
// several debounce delays, including zero and the largest value. Every fire
// beat is checked against its table row or a per-button counter model.
// ----------------------------------------------------------------------------
module tb;

	localparam int          STALL_LIMIT = 5000;
	localparam int          IDLE_PCT    = 31;
	localparam logic [14:0] DELAY_MAX   = 15'h7FFF;
	localparam logic [dbm_pkg::PADDR_W-1:0] DELAY_ADDR =
		dbm_pkg::PADDR_W'(4 * int'(dbm_pkg::REG_DEBOUNCE_DELAY));

	typedef enum logic [1:0] {FIRE_LOW, FIRE_HIGH, FIRE_PREDICT} want_t;

	typedef struct packed {
		logic        wr;
		logic [14:0] dly;
		logic [7:0]  pv;
		logic [2:0]  btn;
		logic        md;
		want_t       want;
	} poll_row_t;

	// directed polls; rows with wr set load debounce_delay instead
	localparam int PLAN_LEN = 27;
	localparam poll_row_t PLAN [PLAN_LEN] = '{
		'{1'b0, 15'd0, 8'h00, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_LOW},
		'{1'b0, 15'd0, 8'hFF, 3'd1, dbm_pkg::MODE_REPEAT,   FIRE_LOW},
		'{1'b1, 15'd0, 8'h00, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hFE, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_HIGH},
		'{1'b0, 15'd0, 8'hFE, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_LOW},
		'{1'b0, 15'd0, 8'hFF, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_LOW},
		'{1'b0, 15'd0, 8'h7F, 3'd7, dbm_pkg::MODE_ON_CLICK, FIRE_HIGH},
		'{1'b0, 15'd0, 8'h7F, 3'd7, dbm_pkg::MODE_REPEAT,   FIRE_LOW},
		'{1'b0, 15'd0, 8'h7F, 3'd7, dbm_pkg::MODE_REPEAT,   FIRE_HIGH},
		'{1'b0, 15'd0, 8'hFF, 3'd7, dbm_pkg::MODE_REPEAT,   FIRE_LOW},
		'{1'b0, 15'd0, 8'hFF, 3'd7, dbm_pkg::MODE_REPEAT,   FIRE_LOW},
		'{1'b1, 15'd1, 8'h00, 3'd0, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hF7, 3'd3, dbm_pkg::MODE_REPEAT,   FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'h20, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'h20, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'h20, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT},
		'{1'b0, 15'd0, 8'hDF, 3'd5, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT}
	};

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic [dbm_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [dbm_pkg::M_TDATA_W-1:0] m_tdata;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [dbm_pkg::PADDR_W-1:0]   paddr    = '0;
	logic [dbm_pkg::PDATA_W-1:0]   pwdata   = '0;
	logic [dbm_pkg::PDATA_W-1:0]   prdata;
	logic                          pready;

	button_debounce_with_modes dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// per-button debounce state as the block should hold it
	logic [dbm_pkg::COUNT_BITS_DEF-1:0] press_cnt   [dbm_pkg::BUTTONS_DEF];
	logic [dbm_pkg::COUNT_BITS_DEF-1:0] release_cnt [dbm_pkg::BUTTONS_DEF];
	logic                               btn_latched [dbm_pkg::BUTTONS_DEF];
	logic [dbm_pkg::DELAY_W-1:0]        delay_now = dbm_pkg::DELAY_RESET;

	bit          fire_due [$];
	want_t       pend_want    = FIRE_PREDICT;
	bit          calm         = 1'b0;
	int unsigned mismatches   = 0;
	int unsigned polls_seen   = 0;
	int unsigned fires_seen   = 0;
	int unsigned delay_writes = 0;
	int unsigned stall_cycles = 0;

	initial begin
		foreach (press_cnt[i]) begin
			press_cnt[i]   = '0;
			release_cnt[i] = '0;
			btn_latched[i] = 1'b0;
		end
	end

	function automatic logic [dbm_pkg::COUNT_BITS_DEF-1:0] sat_inc(
			input logic [dbm_pkg::COUNT_BITS_DEF-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	function automatic bit debounce_fire(input logic [7:0] pv, input logic [2:0] b,
			input logic md);
		bit hit;
		bit relax;
		bit fire;
		hit   = (pv[b] == 1'b0);
		fire  = 1'b0;
		// a latched repeat button counts its hold-off whatever the pin shows
		relax = (md == dbm_pkg::MODE_REPEAT && btn_latched[b])
			|| (md == dbm_pkg::MODE_ON_CLICK && !hit);
		if (relax) begin
			press_cnt[b]   = '0;
			release_cnt[b] = sat_inc(release_cnt[b]);
			if (release_cnt[b] > delay_now) begin
				btn_latched[b] = 1'b0;
				release_cnt[b] = '0;
			end
		end else if (hit) begin
			press_cnt[b]   = sat_inc(press_cnt[b]);
			release_cnt[b] = '0;
			if (press_cnt[b] > delay_now) begin
				if (!btn_latched[b]) begin
					btn_latched[b] = 1'b1;
					fire = 1'b1;
				end
				press_cnt[b] = '0;
			end
		end
		return fire;
	endfunction

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// expectations are queued before the output is checked, so any latency works
	always @(posedge clk) begin : scoreboard
		bit f;
		bit accepted;
		accepted = 1'b0;
		if (s_tvalid && s_tready) begin
			f = debounce_fire(s_tdata[7:0], s_tdata[10:8], s_tdata[11]);
			if (pend_want != FIRE_PREDICT)
				f = (pend_want == FIRE_HIGH);
			fire_due.push_back(f);
			polls_seen++;
			accepted = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			accepted = 1'b1;
			if (fire_due.size() == 0) begin
				$error("fire beat %0b with no poll outstanding", m_tdata[0]);
				mismatches++;
			end else begin
				f = fire_due.pop_front();
				if (m_tdata[0] !== f) begin
					$error("fire: expected %0b, got %0b", f, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[dbm_pkg::M_TDATA_W-1:1] !== '0) begin
					$error("m_tdata pad: expected 0, got %0h",
						m_tdata[dbm_pkg::M_TDATA_W-1:1]);
					mismatches++;
				end
				if (m_tdata[0] === 1'b1)
					fires_seen++;
			end
		end
		stall_cycles = accepted ? 0 : stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (fire_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_poll(input logic [7:0] pv, input logic [2:0] b, input logic md,
			input want_t w);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata   <= {4'h0, md, b, pv};
		s_tvalid  <= 1'b1;
		pend_want <= w;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// write debounce_delay while idle, then read it back
	task automatic set_delay(input logic [dbm_pkg::DELAY_W-1:0] v);
		wait_drained();
		repeat (4) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= DELAY_ADDR;
		pwdata  <= dbm_pkg::PDATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		delay_now = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== dbm_pkg::PDATA_W'(v)) begin
			$error("prdata: expected %0d, got %0d", v, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		delay_writes++;
	endtask

	// mostly clean press-then-release runs on one button, some bouncing noise
	task automatic run_polls(input int n);
		int          sent;
		int          span;
		int          np;
		int          nr;
		logic [2:0]  b;
		logic        md;
		logic [7:0]  pv;
		sent = 0;
		while (sent < n) begin
			b    = 3'($urandom_range(0, 7));
			md   = 1'($urandom_range(0, 1));
			span = (2 * int'(delay_now) + 4 > 250) ? 250 : 2 * int'(delay_now) + 4;
			if ($urandom_range(0, 9) < 7) begin
				np = $urandom_range(1, span);
				nr = $urandom_range(1, span);
				repeat (np) begin
					pv    = 8'($urandom);
					pv[b] = 1'b0;
					send_poll(pv, b, md, FIRE_PREDICT);
				end
				repeat (nr) begin
					pv    = 8'($urandom);
					pv[b] = 1'b1;
					send_poll(pv, b, md, FIRE_PREDICT);
				end
				sent += np + nr;
			end else begin
				np = $urandom_range(1, 8);
				repeat (np) begin
					if ($urandom_range(0, 1))
						b = 3'($urandom_range(0, 7));
					send_poll(8'($urandom), b, 1'($urandom_range(0, 1)), FIRE_PREDICT);
				end
				sent += np;
			end
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end
	endtask

	initial begin : stimulus
		logic [dbm_pkg::DELAY_W-1:0] d;
		logic [2:0]                  hb;
		logic [7:0]                  pv;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].wr)
				set_delay(PLAN[i].dly);
			else
				send_poll(PLAN[i].pv, PLAN[i].btn, PLAN[i].md, PLAN[i].want);
		end

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: d = 15'd0;
				1: d = 15'd2;
				2: d = 15'd1;
				3: d = dbm_pkg::DELAY_W'($urandom_range(3, 12));
				4: d = dbm_pkg::DELAY_RESET;
				default: d = 15'd0;
			endcase
			set_delay(d);
			calm = (ph == 2);
			run_polls(250);
		end
		calm = 1'b0;

		// largest delay: unlatch one button at zero delay, then hold it well short of it
		hb = 3'($urandom_range(0, 7));
		set_delay(15'd0);
		send_poll(8'hFF, hb, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT);
		set_delay(DELAY_MAX);
		repeat (16) begin
			pv     = 8'($urandom);
			pv[hb] = 1'b0;
			send_poll(pv, hb, dbm_pkg::MODE_ON_CLICK, FIRE_PREDICT);
		end
		run_polls(40);

		set_delay(dbm_pkg::DELAY_W'($urandom_range(0, 4)));
		run_polls(100);

		wait_drained();
		repeat (8) @(negedge clk);

		$display("%0d polls checked over %0d delay loads (0 up to %0d), %0d fire beats",
			polls_seen, delay_writes, DELAY_MAX, fires_seen);
		$display("on-click and auto-repeat runs on all buttons, with and without stalls");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
